// File: rtl/volume_level_tracker_motor_drive_assert.svh
`ifndef VOLUME_LEVEL_TRACKER_MOTOR_DRIVE_ASSERT_SVH
`define VOLUME_LEVEL_TRACKER_MOTOR_DRIVE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define VLTMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define VLTMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vltmd_pkg.sv
package vltmd_pkg;

  localparam int NUM_LEVELS = 40;
  localparam int ADC_BITS   = 10;
  localparam int STEP_W     = 10;
  localparam int HYST_W     = 9;
  localparam int LEVEL_W    = 6;
  localparam int TARGET_W   = 8;

  localparam int MUL_W = $clog2(NUM_LEVELS) + STEP_W + 1;
  localparam int SMP_W = ADC_BITS + 1;
  localparam int BND_W = (MUL_W > SMP_W) ? MUL_W : SMP_W;

  localparam int QDEPTH = 2;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [STEP_W-1:0]   RESET_STEP   = STEP_W'(24);
  localparam logic [HYST_W-1:0]   RESET_HYST   = HYST_W'(10);
  localparam logic [TARGET_W-1:0] RESET_TARGET = TARGET_W'(20);

  typedef enum logic [0:0] {
    REG_STEP = 1'b0,
    REG_HYST = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_ADC  = 2'd0,
    FUNC_UP   = 2'd1,
    FUNC_DOWN = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIR_STOP  = 2'd0,
    DIR_LOWER = 2'd1,
    DIR_RAISE = 2'd2
  } dir_t;

  typedef logic [BND_W-1:0] bnd_t;

  typedef struct packed {
    logic [HYST_W-1:0]         hyst;
    bnd_t [NUM_LEVELS-1:1]     lo;
    bnd_t [NUM_LEVELS-1:0]     hi;
  } cfg_t;

  typedef struct packed {
    func_t               func;
    logic                hit;
    logic [LEVEL_W-1:0]  lvl;
  } op_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_stat_t;

endpackage

// File: rtl/vltmd_cfg.sv
module vltmd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vltmd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [vltmd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [vltmd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready,
  output vltmd_pkg::cfg_t                    cfg
);

  logic [vltmd_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [vltmd_pkg::HYST_W-1:0] hyst_r, hyst_nxt;
  vltmd_pkg::bnd_t [vltmd_pkg::NUM_LEVELS-1:1] lo_r, lo_nxt;
  vltmd_pkg::bnd_t [vltmd_pkg::NUM_LEVELS-1:0] hi_r, hi_nxt;
  vltmd_pkg::reg_idx_t idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = vltmd_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    step_nxt = step_r;
    hyst_nxt = hyst_r;
    if (wr_en) begin
      case (idx)
        vltmd_pkg::REG_STEP: step_nxt = pwdata[vltmd_pkg::STEP_W-1:0];
        vltmd_pkg::REG_HYST: hyst_nxt = pwdata[vltmd_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      vltmd_pkg::REG_STEP: prdata = vltmd_pkg::APB_DATA_W'(step_r);
      vltmd_pkg::REG_HYST: prdata = vltmd_pkg::APB_DATA_W'(hyst_r);
      default:             prdata = '0;
    endcase
  end

  // Window bounds: level i >= 1 spans (i*step + hyst, (i+1)*step - hyst); level 0 spans all below step - hyst.
  always_comb begin
    for (int i = 0; i < vltmd_pkg::NUM_LEVELS; i++) begin
      hi_nxt[i] = vltmd_pkg::BND_W'(step_r) * vltmd_pkg::BND_W'(i + 1);
    end
    for (int i = 1; i < vltmd_pkg::NUM_LEVELS; i++) begin
      lo_nxt[i] = vltmd_pkg::BND_W'(step_r) * vltmd_pkg::BND_W'(i)
                + vltmd_pkg::BND_W'(hyst_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= vltmd_pkg::RESET_STEP;
      hyst_r <= vltmd_pkg::RESET_HYST;
    end else begin
      step_r <= step_nxt;
      hyst_r <= hyst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign cfg.hyst = hyst_r;
  assign cfg.lo   = lo_r;
  assign cfg.hi   = hi_r;

endmodule

// File: rtl/vltmd_front.sv
module vltmd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic [vltmd_pkg::ADC_BITS-1:0]    in_adc_value,
  input  vltmd_pkg::cfg_t                   cfg,
  input  vltmd_pkg::q_stat_t                q_stat,
  output logic                              push,
  output vltmd_pkg::op_t                    push_op
);

  logic                            s1_valid_r, s1_valid_nxt;
  logic [1:0]                      s1_func_r;
  logic [vltmd_pkg::ADC_BITS-1:0]  s1_adc_r;
  vltmd_pkg::bnd_t                 smp;
  vltmd_pkg::bnd_t                 smp_h;
  logic                            hit;
  logic [vltmd_pkg::LEVEL_W-1:0]   lvl;

  assign in_ready = !s1_valid_r || !q_stat.full;
  assign push     = s1_valid_r && !q_stat.full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r <= in_func;
      s1_adc_r  <= in_adc_value;
    end
  end

  // The lowest matching window wins; the zero band beats every window.
  always_comb begin
    smp   = vltmd_pkg::BND_W'(s1_adc_r);
    smp_h = vltmd_pkg::BND_W'(s1_adc_r) + vltmd_pkg::BND_W'(cfg.hyst);
    hit   = 1'b0;
    lvl   = '0;
    for (int i = vltmd_pkg::NUM_LEVELS - 1; i >= 1; i--) begin
      if ((smp > cfg.lo[i]) && (smp_h < cfg.hi[i])) begin
        hit = 1'b1;
        lvl = vltmd_pkg::LEVEL_W'(i);
      end
    end
    if (smp_h < cfg.hi[0]) begin
      hit = 1'b1;
      lvl = '0;
    end
  end

  assign push_op.func = vltmd_pkg::func_t'(s1_func_r);
  assign push_op.hit  = hit;
  assign push_op.lvl  = lvl;

endmodule

// File: rtl/vltmd_queue.sv
module vltmd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  vltmd_pkg::op_t       push_op,
  input  logic                 pop,
  output vltmd_pkg::op_t       pop_op,
  output vltmd_pkg::q_stat_t   stat
);

  vltmd_pkg::op_t                  slot_r [vltmd_pkg::QDEPTH];
  logic [vltmd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [vltmd_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [vltmd_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == vltmd_pkg::QCNT_W'(vltmd_pkg::QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_op     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == vltmd_pkg::QPTR_W'(vltmd_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == vltmd_pkg::QPTR_W'(vltmd_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: rtl/vltmd_back.sv
module vltmd_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vltmd_pkg::q_stat_t                q_stat,
  output logic                              pop,
  input  vltmd_pkg::op_t                    pop_op,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vltmd_pkg::LEVEL_W-1:0]     out_level,
  output logic [vltmd_pkg::TARGET_W-1:0]    out_target_level,
  output logic                              out_level_changed,
  output logic [1:0]                        out_motor_dir
);

  logic                             out_valid_r, out_valid_nxt;
  logic [vltmd_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic [vltmd_pkg::TARGET_W-1:0]   target_r, target_nxt;
  logic                             changed_r, changed_nxt;
  vltmd_pkg::dir_t                  dir_r, dir_nxt;
  logic [vltmd_pkg::TARGET_W-1:0]   level_ext;

  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  always_comb begin
    level_nxt   = level_r;
    target_nxt  = target_r;
    changed_nxt = 1'b0;
    case (pop_op.func)
      vltmd_pkg::FUNC_ADC: begin
        level_nxt = pop_op.hit ? pop_op.lvl : level_r;
        if (vltmd_pkg::TARGET_W'(level_r) == target_r) begin
          target_nxt = vltmd_pkg::TARGET_W'(level_nxt);
        end
        changed_nxt = (level_nxt != level_r);
      end
      vltmd_pkg::FUNC_UP:   target_nxt = target_r + 1'b1;
      vltmd_pkg::FUNC_DOWN: target_nxt = target_r - 1'b1;
      default: ;
    endcase
    level_ext = vltmd_pkg::TARGET_W'(level_nxt);
    if (target_nxt == level_ext) begin
      dir_nxt = vltmd_pkg::DIR_STOP;
    end else if (target_nxt < level_ext) begin
      dir_nxt = vltmd_pkg::DIR_LOWER;
    end else begin
      dir_nxt = vltmd_pkg::DIR_RAISE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      level_r     <= '0;
      target_r    <= vltmd_pkg::RESET_TARGET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        level_r  <= level_nxt;
        target_r <= target_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      changed_r <= changed_nxt;
      dir_r     <= dir_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level         = level_r;
  assign out_target_level  = target_r;
  assign out_level_changed = changed_r;
  assign out_motor_dir     = dir_r;

endmodule

// File: rtl/volume_level_tracker_motor_drive.sv
// Level tracker and motor drive for a motorised volume control.
// The in_ channel takes one beat per item: in_func selects an adc sample,
// a target step up, a target step down or no command, and in_adc_value
// carries the sample. The out_ channel returns one beat per item with the
// level, the target, the level-changed flag and the motor direction.
// The user writes step size and hysteresis over the APB port while idle;
// the block does not enforce this. A result beat moves from the input
// register via a queue slot to the output registers; one item per cycle is
// sustained while out_ready stays high: level windows are checked by one
// bank of parallel comparators against registered window bounds, and the
// level and target update is a single step. A two-entry queue sits between
// classification and the state update, so the input side keeps accepting
// beats while a result waits; when the receiver stalls, the queue fills and in_ready then drops.
// Synchronous reset sets level 0, target 20, step 24 and hysteresis 10,
// and empties the pipeline.
module volume_level_tracker_motor_drive (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_func,
  input  logic [vltmd_pkg::ADC_BITS-1:0]     in_adc_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vltmd_pkg::LEVEL_W-1:0]      out_level,
  output logic [vltmd_pkg::TARGET_W-1:0]     out_target_level,
  output logic                               out_level_changed,
  output logic [1:0]                         out_motor_dir,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vltmd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [vltmd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [vltmd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready
);

`include "volume_level_tracker_motor_drive_assert.svh"

  vltmd_pkg::cfg_t     cfg;
  vltmd_pkg::q_stat_t  q_stat;
  vltmd_pkg::op_t      push_op;
  vltmd_pkg::op_t      pop_op;
  logic                push;
  logic                pop;

  vltmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vltmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_adc_value (in_adc_value),
    .cfg          (cfg),
    .q_stat       (q_stat),
    .push         (push),
    .push_op      (push_op)
  );

  vltmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .stat    (q_stat)
  );

  vltmd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .pop               (pop),
    .pop_op            (pop_op),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level         (out_level),
    .out_target_level  (out_target_level),
    .out_level_changed (out_level_changed),
    .out_motor_dir     (out_motor_dir)
  );

  `VLTMD_ASSERT_NOW(a_dir_stop_match, out_valid, ((out_motor_dir == vltmd_pkg::DIR_STOP) == (out_target_level == vltmd_pkg::TARGET_W'(out_level))), "motor direction disagrees with level and target")
  `VLTMD_ASSERT_NOW(a_level_range, out_valid, (out_level < vltmd_pkg::LEVEL_W'(vltmd_pkg::NUM_LEVELS)), "level out of range")
  `VLTMD_ASSERT_NEXT(a_drain, (out_valid && out_ready && !q_stat.empty), out_valid, "queued beat not moved to the output")
  `VLTMD_ASSERT_NOW(a_queue_bound, 1'b1, (q_stat.count <= vltmd_pkg::QCNT_W'(vltmd_pkg::QDEPTH)), "queue overfilled")

endmodule

// File: sim/volume_level_tracker_motor_drive_tb.sv
`timescale 1ns / 1ps

module volume_level_tracker_motor_drive_tb;
  import vltmd_pkg::*;

  localparam int PHASES           = 13;
  localparam int RANDOM_PER_PHASE = 56;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 4;
  localparam int MAX_PRINTED      = 40;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [TARGET_W-1:0] target;
    logic                changed;
    dir_t                dir;
  } status_t;

  typedef struct packed {
    func_t               func;
    logic [ADC_BITS-1:0] adc;
    logic                typed;
    status_t             want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_func = FUNC_NONE;
  logic [ADC_BITS-1:0]   in_adc_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LEVEL_W-1:0]    out_level;
  logic [TARGET_W-1:0]   out_target_level;
  logic                  out_level_changed;
  logic [1:0]            out_motor_dir;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [STEP_W-1:0]     step_cfg = RESET_STEP;
  logic [HYST_W-1:0]     hyst_cfg = RESET_HYST;
  logic [LEVEL_W-1:0]    level_now = '0;
  logic [TARGET_W-1:0]   target_now = RESET_TARGET;
  status_t               expected_status_q[$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  int                    burst_left = 0;
  bit                    gaps_on = 1'b1;
  logic [15:0]           stall_pattern = '1;

  logic [STEP_W-1:0] phase_step [PHASES] =
    '{10'd24, 10'd1, 10'd1023, 10'd0, 10'd0, 10'd8, 10'd5, 10'd25, 10'd26, 10'd100,
      10'd1023, 10'd2, 10'd4};
  logic [HYST_W-1:0] phase_hyst [PHASES] =
    '{9'd10, 9'd0, 9'd511, 9'd0, 9'd7, 9'd8, 9'd511, 9'd12, 9'd0, 9'd49,
      9'd0, 9'd0, 9'd1};

  row_t directed_rows [20] = '{
    '{FUNC_NONE, 10'd0,    1'b1, '{6'd0,  8'd20,  1'b0, DIR_RAISE}},
    '{FUNC_ADC,  10'd0,    1'b1, '{6'd0,  8'd20,  1'b0, DIR_RAISE}},
    '{FUNC_ADC,  10'd1023, 1'b0, '0},
    '{FUNC_ADC,  10'd492,  1'b1, '{6'd20, 8'd20,  1'b1, DIR_STOP}},
    '{FUNC_NONE, 10'd1023, 1'b1, '{6'd20, 8'd20,  1'b0, DIR_STOP}},
    '{FUNC_ADC,  10'd12,   1'b1, '{6'd0,  8'd0,   1'b1, DIR_STOP}},
    '{FUNC_DOWN, 10'd0,    1'b1, '{6'd0,  8'd255, 1'b0, DIR_RAISE}},
    '{FUNC_UP,   10'd1023, 1'b1, '{6'd0,  8'd0,   1'b0, DIR_STOP}},
    '{FUNC_ADC,  10'd948,  1'b0, '0},
    '{FUNC_DOWN, 10'd682,  1'b0, '0},
    '{FUNC_ADC,  10'd950,  1'b0, '0},
    '{FUNC_ADC,  10'd946,  1'b0, '0},
    '{FUNC_ADC,  10'd13,   1'b0, '0},
    '{FUNC_ADC,  10'd14,   1'b0, '0},
    '{FUNC_ADC,  10'd35,   1'b0, '0},
    '{FUNC_ADC,  10'd34,   1'b0, '0},
    '{FUNC_UP,   10'd341,  1'b0, '0},
    '{FUNC_UP,   10'd682,  1'b0, '0},
    '{FUNC_ADC,  10'd682,  1'b0, '0},
    '{FUNC_ADC,  10'd683,  1'b0, '0}
  };

  volume_level_tracker_motor_drive u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_adc_value      (in_adc_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level         (out_level),
    .out_target_level  (out_target_level),
    .out_level_changed (out_level_changed),
    .out_motor_dir     (out_motor_dir),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk = ~clk;

  function automatic logic [LEVEL_W-1:0] quantize_level(logic [ADC_BITS-1:0] smp,
                                                        logic [LEVEL_W-1:0] old_level);
    int s;
    int st;
    int hy;
    int base;
    s  = int'(smp);
    st = int'(step_cfg);
    hy = int'(hyst_cfg);
    if (s < st - hy) return '0;
    for (int i = 1; i < NUM_LEVELS; i++) begin
      base = st * i;
      if (s > base + hy && s < base + st - hy) return LEVEL_W'(i);
    end
    return old_level;
  endfunction

  function automatic status_t advance_tracker(func_t f, logic [ADC_BITS-1:0] smp);
    status_t r;
    logic [LEVEL_W-1:0] prev;
    r.changed = 1'b0;
    case (f)
      FUNC_ADC: begin
        prev = level_now;
        level_now = quantize_level(smp, prev);
        if (prev == target_now) target_now = TARGET_W'(level_now);
        r.changed = (prev != level_now);
      end
      FUNC_UP:   target_now = target_now + 8'd1;
      FUNC_DOWN: target_now = target_now - 8'd1;
      default: ;
    endcase
    r.level  = level_now;
    r.target = target_now;
    if (target_now == TARGET_W'(level_now)) r.dir = DIR_STOP;
    else if (target_now < TARGET_W'(level_now)) r.dir = DIR_LOWER;
    else r.dir = DIR_RAISE;
    return r;
  endfunction

  // Samples are mostly aimed at window centres and edges so that levels move.
  function automatic logic [ADC_BITS-1:0] pick_sample();
    int v;
    int i;
    int st;
    int hy;
    st = int'(step_cfg);
    hy = int'(hyst_cfg);
    i  = $urandom_range(0, NUM_LEVELS - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = i * st + st / 2 + $urandom_range(0, 4) - 2;
      4, 5:       v = i * st + hy + $urandom_range(0, 1);
      6:          v = i * st + st - hy - $urandom_range(0, 1);
      7:          v = (target_now < NUM_LEVELS) ? int'(target_now) * st + st / 2 : i * st;
      default:    v = $urandom_range(0, 1023);
    endcase
    if (v < 0 || v > 1023) v = $urandom_range(0, 1023);
    return ADC_BITS'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(logic [STEP_W-1:0] st, logic [HYST_W-1:0] hy);
    reg_idx_t ri;
    for (int r = 0; r < 2; r++) begin
      ri = (r == 0) ? REG_STEP : REG_HYST;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {ri, 2'b00};
      pwdata  <= (ri == REG_STEP) ? APB_DATA_W'(st) : APB_DATA_W'(hy);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    step_cfg = st;
    hyst_cfg = hy;
  endtask

  task automatic send_item(func_t f, logic [ADC_BITS-1:0] smp, logic typed, status_t want);
    status_t predicted;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_func      <= f;
    in_adc_value <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_tracker(f, smp);
    expected_status_q.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[5:0] == 6'd0)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom | $urandom);
    out_ready <= stall_pattern[cycle_count[3:0]];
    if (cycle_count > CYCLE_LIMIT) begin
      $display("volume_level_tracker_motor_drive_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = expected_status_q.pop_front();
        if (out_level !== want.level)
          report_mismatch("level", out_level, want.level);
        if (out_target_level !== want.target)
          report_mismatch("target_level", out_target_level, want.target);
        if (out_level_changed !== want.changed)
          report_mismatch("level_changed", out_level_changed, want.changed);
        if (out_motor_dir !== want.dir)
          report_mismatch("motor_dir", out_motor_dir, want.dir);
      end
    end
  end

  initial begin : stimulus
    func_t f;
    logic [ADC_BITS-1:0] smp;
    int pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[k])
      send_item(directed_rows[k].func, directed_rows[k].adc, directed_rows[k].typed,
                directed_rows[k].want);
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        apply_settings(phase_step[p], phase_hyst[p]);
        @(posedge clk);
      end
      gaps_on = (p % 3 != 1);
      burst_left = 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 5 && n == RANDOM_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        pick = $urandom_range(0, 19);
        if (pick < 12) f = FUNC_ADC;
        else if (pick < 15) f = FUNC_UP;
        else if (pick < 18) f = FUNC_DOWN;
        else f = FUNC_NONE;
        smp = (f == FUNC_ADC) ? pick_sample() : ADC_BITS'($urandom_range(0, 1023));
        send_item(f, smp, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (expected_status_q.size() != 0)
      report_mismatch("results left outstanding", 0, expected_status_q.size());
    if (mismatch_count == 0) begin
      $display("volume_level_tracker_motor_drive_tb passed");
    end else begin
      $display("volume_level_tracker_motor_drive_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/vltmd_pkg.sv
rtl/vltmd_cfg.sv
rtl/vltmd_front.sv
rtl/vltmd_queue.sv
rtl/vltmd_back.sv
rtl/volume_level_tracker_motor_drive.sv
sim/volume_level_tracker_motor_drive_tb.sv
